>>> design/cts_pkg.sv
// Shared types and constants of the C subset token scanner.
// Holds the token record, the token kind codes and the output queue sizing.
// No dependencies.
package cts_pkg;

  // Text offsets and token lengths wrap at 2^16 bytes
  localparam int unsigned POS_W = 16;

  // Output queue: two tokens can follow one byte, so keep room for two more
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned FILL_W     = 3;

  typedef enum logic [2:0] {
    KIND_NUM     = 3'd0,
    KIND_PUNCT   = 3'd1,
    KIND_KEYWORD = 3'd2,
    KIND_IDENT   = 3'd3,
    KIND_END     = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   length;
    logic [31:0]        value;
    logic [7:0]         first_char;
    logic [7:0]         second_char;
    logic [1:0]         keyword_id;
    logic               last;
  } tok_t;

  // Tokens produced by one source byte, in emission order
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } tok_pair_t;

endpackage

>>> design/c_subset_token_scanner.sv
// Top level of the C subset token scanner: byte input channel, token output queue.
// Depends on cts_pkg and cts_scan.
//
// Usage:
//   Source bytes enter on ch with in_valid/in_ready; byte 0 ends a text, yields an
//   end token and restarts offsets at 0 for the next text.
//   Tokens leave on out_valid/out_ready, one per transfer, fields as separate
//   ports; last marks the final token caused by one source byte.
//   A token caused by a byte is written to the output queue on that byte's transfer
//   and presented once the tokens ahead of it have left (one register stage, the queue).
//   Throughput: one byte per cycle while the receiver takes one token per cycle.
//   A byte can cause two tokens; the four-entry output queue takes a byte only
//   while at least two entries are free, so even with the receiver always ready
//   bytes that cause two tokens slow the byte input.
//   Reset (rst, synchronous) empties the queue and returns the scanner to the
//   start of a text at offset 0.
//   When the receiver stalls, tokens stay queued unchanged and in_ready drops
//   once fewer than two entries are free.
module c_subset_token_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [15:0] start_pos,
  output logic [15:0] length,
  output logic [31:0] value,
  output logic [7:0]  first_char,
  output logic [7:0]  second_char,
  output logic [1:0]  keyword_id,
  output logic        last
);

  logic               in_xfer, out_xfer;
  cts_pkg::tok_pair_t res;
  cts_pkg::tok_t      fifo_mem [cts_pkg::FIFO_DEPTH];
  cts_pkg::tok_t      head;
  logic [cts_pkg::PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [cts_pkg::FILL_W-1:0] fill, fill_next, enq;

  assign in_ready = fill <= cts_pkg::FILL_W'(cts_pkg::FIFO_DEPTH - 2);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = fill != '0;
  assign out_xfer  = out_valid && out_ready;

  cts_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (in_xfer),
    .ch   (ch),
    .res  (res)
  );

  // Queue occupancy
  assign enq       = in_xfer ? {1'b0, res.count} : '0;
  assign fill_next = fill + enq - {{(cts_pkg::FILL_W-1){1'b0}}, out_xfer};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + enq[cts_pkg::PTR_W-1:0];
      if (out_xfer) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  // Write the tokens of an accepted byte in order
  always_ff @(posedge clk) begin
    if (in_xfer && res.count != 2'd0) begin
      fifo_mem[wr_ptr] <= res.first;
    end
    if (in_xfer && res.count == 2'd2) begin
      fifo_mem[wr_ptr + 1'b1] <= res.second;
    end
  end

  // Present the queue head
  assign head        = fifo_mem[rd_ptr];
  assign kind        = head.kind;
  assign start_pos   = head.start_pos;
  assign length      = head.length;
  assign value       = head.value;
  assign first_char  = head.first_char;
  assign second_char = head.second_char;
  assign keyword_id  = head.keyword_id;
  assign last        = head.last;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cts_pkg::FILL_W'(cts_pkg::FIFO_DEPTH))
    else $error("output queue overfilled");

  a_drain_only: assert property (@(posedge clk) disable iff (rst)
    out_xfer && !in_xfer |=> fill == $past(fill) - 1'b1)
    else $error("queue count wrong after a plain drain");

  a_fill_only: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !out_xfer |=> fill == $past(fill) + {1'b0, $past(res.count)})
    else $error("queue count wrong after an accepted byte");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr - rd_ptr == fill[cts_pkg::PTR_W-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

>>> design/cts_scan.sv
// Scanner state and per-byte token logic of the C subset token scanner.
// Produces up to two tokens for the byte on ch and advances state on step.
// Depends on cts_pkg.
module cts_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          ch,
  output cts_pkg::tok_pair_t  res
);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_IDENT = 3'd2,
    MODE_KW    = 3'd3,
    MODE_PEND  = 3'd4,
    MODE_SKIP  = 3'd5
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_BANG  = "!";
  localparam logic [7:0] CH_LT    = "<";
  localparam logic [7:0] CH_GT    = ">";
  localparam logic [7:0] CH_UNDER = "_";

  localparam logic [1:0] KW_RETURN = 2'd0;
  localparam logic [1:0] KW_IF     = 2'd1;
  localparam logic [1:0] KW_ELSE   = 2'd2;

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  // Keyword spelling tables
  function automatic logic [2:0] kw_len(input logic [1:0] sel);
    logic [2:0] r;
    unique case (sel)
      KW_RETURN: r = 3'd6;
      KW_IF:     r = 3'd2;
      default:   r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] k);
    logic [7:0] r;
    r = CH_NUL;
    unique case (sel)
      KW_RETURN: begin
        unique case (k)
          3'd0:    r = "r";
          3'd1:    r = "e";
          3'd2:    r = "t";
          3'd3:    r = "u";
          3'd4:    r = "r";
          3'd5:    r = "n";
          default: r = CH_NUL;
        endcase
      end
      KW_IF: begin
        unique case (k)
          3'd0:    r = "i";
          3'd1:    r = "f";
          default: r = CH_NUL;
        endcase
      end
      default: begin
        unique case (k)
          3'd0:    r = "e";
          3'd1:    r = "l";
          3'd2:    r = "s";
          3'd3:    r = "e";
          default: r = CH_NUL;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic cts_pkg::tok_t mk_tok(
    input cts_pkg::kind_t              kd,
    input logic [cts_pkg::POS_W-1:0]   st,
    input logic [cts_pkg::POS_W-1:0]   ln,
    input logic [31:0]                 v,
    input logic [7:0]                  c1,
    input logic [7:0]                  c2,
    input logic [1:0]                  kw
  );
    cts_pkg::tok_t t;
    t.kind        = kd;
    t.start_pos   = st;
    t.length      = ln;
    t.value       = v;
    t.first_char  = c1;
    t.second_char = c2;
    t.keyword_id  = kw;
    t.last        = 1'b0;
    return t;
  endfunction

  // State registers
  mode_t                    mode, mode_next;
  logic [2:0]               kw_alive, kw_alive_next;
  logic [1:0]               kw_sel, kw_sel_next;
  logic [cts_pkg::POS_W-1:0] token_start, token_start_next;
  logic [cts_pkg::POS_W-1:0] position, position_next;
  logic [31:0]              number_acc, number_acc_next;
  logic [7:0]               pending_char, pending_char_next;

  // Work items of the byte logic
  cts_pkg::tok_t             tok_m, tok_f;
  logic                      m_valid, f_valid, fresh, end_text;
  logic [cts_pkg::POS_W-1:0] span;
  logic [35:0]               acc_sum;
  logic [1:0]                sel;
  logic [2:0]                klen, k;

  assign span    = position - token_start;
  assign acc_sum = {4'd0, number_acc} * 36'd10 + {32'd0, ch[3:0]};
  assign sel     = (kw_sel == KW_RETURN || kw_sel == KW_IF) ? kw_sel : KW_ELSE;
  assign klen    = kw_len(sel);
  assign k       = (kw_alive < klen) ? kw_alive : 3'd0;

  // Token logic: close the running token, then start from this byte
  always_comb begin
    mode_next         = mode;
    kw_alive_next     = kw_alive;
    kw_sel_next       = kw_sel;
    token_start_next  = token_start;
    position_next     = position + 1'b1;
    number_acc_next   = number_acc;
    pending_char_next = pending_char;
    tok_m             = '0;
    tok_f             = '0;
    m_valid           = 1'b0;
    f_valid           = 1'b0;
    fresh             = 1'b0;
    end_text          = 1'b0;

    unique case (mode)
      MODE_NUM: begin
        if (is_digit(ch)) begin
          number_acc_next = (acc_sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_sum[31:0];
        end else begin
          tok_m   = mk_tok(cts_pkg::KIND_NUM, token_start, span, number_acc,
                           CH_NUL, CH_NUL, KW_RETURN);
          m_valid = 1'b1;
          fresh   = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!is_word(ch)) begin
          tok_m   = mk_tok(cts_pkg::KIND_IDENT, token_start, span, 32'd0,
                           CH_NUL, CH_NUL, KW_RETURN);
          m_valid = 1'b1;
          fresh   = 1'b1;
        end
      end
      MODE_KW: begin
        if (ch == kw_char(sel, k)) begin
          kw_alive_next = k + 3'd1;
          if (k + 3'd1 >= klen) begin
            tok_m         = mk_tok(cts_pkg::KIND_KEYWORD, token_start,
                                   {{(cts_pkg::POS_W-3){1'b0}}, klen}, 32'd0,
                                   CH_NUL, CH_NUL, sel);
            m_valid       = 1'b1;
            mode_next     = MODE_IDLE;
            kw_alive_next = 3'd0;
          end
        end else if (is_word(ch)) begin
          mode_next     = MODE_IDENT;
          kw_alive_next = 3'd0;
        end else begin
          tok_m         = mk_tok(cts_pkg::KIND_IDENT, token_start, span, 32'd0,
                                 CH_NUL, CH_NUL, KW_RETURN);
          m_valid       = 1'b1;
          kw_alive_next = 3'd0;
          fresh         = 1'b1;
        end
      end
      MODE_PEND: begin
        if (ch == CH_EQ) begin
          tok_m     = mk_tok(cts_pkg::KIND_PUNCT, token_start, 16'd2, 32'd0,
                             pending_char, ch, KW_RETURN);
          m_valid   = 1'b1;
          mode_next = MODE_IDLE;
        end else begin
          tok_m   = mk_tok(cts_pkg::KIND_PUNCT, token_start, 16'd1, 32'd0,
                           pending_char, CH_NUL, KW_RETURN);
          m_valid = 1'b1;
          fresh   = 1'b1;
        end
        pending_char_next = CH_NUL;
      end
      MODE_SKIP: begin
        if (ch == CH_NUL) begin
          tok_f    = mk_tok(cts_pkg::KIND_END, position, 16'd1, 32'd0,
                            CH_NUL, CH_NUL, KW_RETURN);
          f_valid  = 1'b1;
          end_text = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // Start a new token from this byte
    if (fresh) begin
      mode_next = MODE_IDLE;
      priority if (ch == CH_NUL) begin
        tok_f    = mk_tok(cts_pkg::KIND_END, position, 16'd1, 32'd0,
                          CH_NUL, CH_NUL, KW_RETURN);
        f_valid  = 1'b1;
        end_text = 1'b1;
      end else if (is_space(ch)) begin
        mode_next = MODE_IDLE;
      end else if (is_digit(ch)) begin
        mode_next        = MODE_NUM;
        token_start_next = position;
        number_acc_next  = {28'd0, ch[3:0]};
      end else if (ch == CH_EQ || ch == CH_BANG || ch == CH_LT || ch == CH_GT) begin
        mode_next         = MODE_PEND;
        token_start_next  = position;
        pending_char_next = ch;
      end else if (is_punct(ch)) begin
        tok_f   = mk_tok(cts_pkg::KIND_PUNCT, position, 16'd1, 32'd0,
                         ch, CH_NUL, KW_RETURN);
        f_valid = 1'b1;
      end else if (is_alpha(ch)) begin
        token_start_next = position;
        if (ch == "r" || ch == "i" || ch == "e") begin
          mode_next     = MODE_KW;
          kw_sel_next   = (ch == "r") ? KW_RETURN : ((ch == "i") ? KW_IF : KW_ELSE);
          kw_alive_next = 3'd1;
        end else begin
          mode_next = MODE_IDENT;
        end
      end else begin
        tok_f     = mk_tok(cts_pkg::KIND_ERROR, position, 16'd1, 32'd0,
                           ch, CH_NUL, KW_RETURN);
        f_valid   = 1'b1;
        mode_next = MODE_SKIP;
      end
    end

    // End byte: drop all state so the next byte opens a new text
    if (end_text) begin
      mode_next         = MODE_IDLE;
      kw_alive_next     = 3'd0;
      kw_sel_next       = KW_RETURN;
      token_start_next  = '0;
      position_next     = '0;
      number_acc_next   = 32'd0;
      pending_char_next = CH_NUL;
    end
  end

  // Pack tokens in order and flag the last one
  always_comb begin
    res = '0;
    if (m_valid) begin
      res.first  = tok_m;
      res.second = tok_f;
      res.count  = f_valid ? 2'd2 : 2'd1;
    end else begin
      res.first  = tok_f;
      res.count  = f_valid ? 2'd1 : 2'd0;
    end
    if (res.count == 2'd1) begin
      res.first.last = 1'b1;
    end
    if (res.count == 2'd2) begin
      res.second.last = 1'b1;
    end
  end

  // Hold state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      kw_alive     <= 3'd0;
      kw_sel       <= KW_RETURN;
      token_start  <= '0;
      position     <= '0;
      number_acc   <= 32'd0;
      pending_char <= CH_NUL;
    end else if (step) begin
      mode         <= mode_next;
      kw_alive     <= kw_alive_next;
      kw_sel       <= kw_sel_next;
      token_start  <= token_start_next;
      position     <= position_next;
      number_acc   <= number_acc_next;
      pending_char <= pending_char_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    step && ch == CH_NUL |=> position == '0 && mode == MODE_IDLE)
    else $error("end byte did not restart the text");

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    step && ch == CH_NUL |->
      (res.count == 2'd1 && res.first.kind == cts_pkg::KIND_END && res.first.last) ||
      (res.count == 2'd2 && res.second.kind == cts_pkg::KIND_END && res.second.last))
    else $error("end byte without a closing end token");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_SKIP && ch != CH_NUL |-> res.count == 2'd0 && mode_next == MODE_SKIP)
    else $error("token emitted while discarding after an error");
`endif

endmodule
